// ----- sv/assert_macros.svh -----
// Assertion macros used by the velocity merge controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on the rising edge of clk outside reset.
`define KCVM_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle implication failed");
// Next-cycle implication, checked on the rising edge of clk outside reset.
`define KCVM_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle implication failed");
`else
`define KCVM_ASSERT_IMP(lbl, a, b)
`define KCVM_ASSERT_NXT(lbl, a, b)
`endif
`endif

// ----- sv/kcvm_pkg.sv -----
// Shared types, codes and defaults for the keyboard coupler velocity merge.
`timescale 1ns / 1ps
package kcvm_pkg;

  localparam int MAX_KEYS_DEF    = 64;
  localparam int NUM_SOURCES_DEF = 8;

  // Input command codes.
  localparam logic [2:0] CMD_NOTE_ON    = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF   = 3'd1;
  localparam logic [2:0] CMD_COUPLER    = 3'd2;
  localparam logic [2:0] CMD_UNISON_SET = 3'd3;
  localparam logic [2:0] CMD_UNISON_CLR = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_OUTPUT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIRST_NOTE        = 2'd0;
  localparam logic [1:0] CFG_FIRST_LOGICAL_KEY = 2'd1;
  localparam logic [1:0] CFG_ACCESSIBLE_KEYS   = 2'd2;
  localparam logic [1:0] CFG_LOGICAL_KEYS      = 2'd3;

  localparam logic [7:0] UNISON_MAX = 8'd255;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [8:0] velocity;
    logic [8:0] remote_velocity;
    logic [6:0] division_note;
    logic       midi_valid;
    logic       in_view;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_PV_CHK, S_SV_RD, S_SV_CHK, S_SCAN, S_UPD,
    S_DRV_CHK, S_RED_RD, S_RED_CHK, S_FIN
  } kcvm_state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_DEC, OP_PV_CHK, OP_SV_RD, OP_SV_CHK, OP_SCAN, OP_UPD,
    OP_DRV_CHK, OP_RED_RD, OP_RED_CHK, OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       win_ok;
    logic       uc_zero;
    logic       uc_one;
    logic       lim_zero;
    logic       key_ok;
    logic       pv_same;
    logic       sv_same;
    logic       scan_last;
    logic       lvl_same;
    logic       red_last;
    logic       can_push;
    logic       pend_valid;
    logic       out_free;
  } stat_t;

endpackage

// ----- sv/kcvm_ctrl.sv -----
// Controller state machine that sequences the velocity merge datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kcvm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  kcvm_pkg::stat_t st,
  output kcvm_pkg::ctl_t  ctl
);
  import kcvm_pkg::*;

  kcvm_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        unique case (st.cmd)
          CMD_NOTE_ON, CMD_NOTE_OFF: state_nxt = st.win_ok ? S_PV_CHK : S_FIN;
          CMD_COUPLER:    state_nxt = S_SV_RD;
          CMD_UNISON_SET: state_nxt = (st.uc_zero && !st.lim_zero) ? S_RED_RD : S_FIN;
          CMD_UNISON_CLR: state_nxt = (st.uc_one && !st.lim_zero) ? S_RED_RD : S_FIN;
          default:        state_nxt = S_FIN;
        endcase
      end
      S_PV_CHK: begin
        if (st.pv_same) state_nxt = S_FIN;
        else if (st.can_push) state_nxt = S_SV_RD;
      end
      S_SV_RD:   state_nxt = st.key_ok ? S_SV_CHK : S_FIN;
      S_SV_CHK:  state_nxt = st.sv_same ? S_FIN : S_SCAN;
      S_SCAN: begin
        if (st.scan_last) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (st.can_push) state_nxt = S_DRV_CHK;
      end
      S_DRV_CHK: begin
        if (st.lvl_same || st.can_push) state_nxt = S_FIN;
      end
      S_RED_RD:  state_nxt = S_RED_CHK;
      S_RED_CHK: begin
        if (st.lvl_same || st.can_push) state_nxt = st.red_last ? S_FIN : S_RED_RD;
      end
      S_FIN: begin
        if (!st.pend_valid || st.out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctl.load = (state_r == S_IDLE) && in_valid;
    in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE:    ctl.op = OP_IDLE;
      S_DEC:     ctl.op = OP_DEC;
      S_PV_CHK:  ctl.op = OP_PV_CHK;
      S_SV_RD:   ctl.op = OP_SV_RD;
      S_SV_CHK:  ctl.op = OP_SV_CHK;
      S_SCAN:    ctl.op = OP_SCAN;
      S_UPD:     ctl.op = OP_UPD;
      S_DRV_CHK: ctl.op = OP_DRV_CHK;
      S_RED_RD:  ctl.op = OP_RED_RD;
      S_RED_CHK: ctl.op = OP_RED_CHK;
      S_FIN:     ctl.op = OP_FIN;
      default:   ctl.op = OP_IDLE;
    endcase
  end

  // No result may still be held back once the block is idle again.
  `KCVM_ASSERT_IMP(a_idle_no_pending, state_r == S_IDLE, !st.pend_valid)
  // An accepted transfer is always decoded next.
  `KCVM_ASSERT_NXT(a_accept_decode, state_r == S_IDLE && in_valid, state_r == S_DEC)
  // The source scan runs without a break until its final entry.
  `KCVM_ASSERT_NXT(a_scan_runs, state_r == S_SCAN && !st.scan_last, state_r == S_SCAN)

endmodule

// ----- sv/kcvm_dp.sv -----
// Datapath: configuration, velocity tables, maxima scan and result staging.
`timescale 1ns / 1ps
module kcvm_dp #(
  parameter int MAX_KEYS    = kcvm_pkg::MAX_KEYS_DEF,
  parameter int NUM_SOURCES = kcvm_pkg::NUM_SOURCES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [6:0]      cfg_data,
  input  logic [2:0]      in_cmd,
  input  logic [6:0]      in_note_num,
  input  logic [5:0]      in_logical_key,
  input  logic [8:0]      in_velocity,
  input  logic [2:0]      in_source,
  input  kcvm_pkg::ctl_t  ctl,
  output kcvm_pkg::stat_t st,
  input  logic            out_ready,
  output logic            out_valid,
  output kcvm_pkg::res_t  out_res,
  output logic            out_last
);
  import kcvm_pkg::*;

  localparam int KW       = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int SW       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int SV_DEPTH = MAX_KEYS * NUM_SOURCES;
  localparam int AW       = (SV_DEPTH > 1) ? $clog2(SV_DEPTH) : 1;
  localparam logic [7:0]    MAXK8    = 8'(MAX_KEYS);
  localparam logic [6:0]    NS7      = 7'(NUM_SOURCES);
  localparam logic [SW-1:0] LAST_SRC = SW'(NUM_SOURCES - 1);

  // Configuration registers.
  logic [6:0] fmn_r, flk_r, acc_r, lk_r;
  // Latched input transfer.
  logic [2:0] cmd_r;
  logic [6:0] note_r;
  logic [5:0] lkey_r;
  logic [8:0] vel_r;
  logic [2:0] src_r;
  // Working registers.
  logic [KW-1:0] key_r;
  logic          key_ok_r;
  logic [SW-1:0] srcw_r;
  logic [8:0]    sval_r;
  logic [6:0]    lvel_r;
  logic [7:0]    ucount_r;
  logic          red_on_r;
  logic [SW-1:0] scan_i_r;
  logic [8:0]    all_r, remote_r;
  // Memories, their read data and valid bits.
  logic [6:0]  pv_mem [MAX_KEYS];
  logic [8:0]  sv_mem [SV_DEPTH];
  logic [17:0] mc_mem [MAX_KEYS];
  logic [6:0]  dl_mem [MAX_KEYS];
  logic [6:0]  pv_q;
  logic [8:0]  sv_q;
  logic [17:0] mc_q;
  logic [6:0]  dl_q;
  logic [MAX_KEYS-1:0] pv_vld_r, row_vld_r, mc_vld_r, dl_vld_r;
  // Result staging.
  res_t pend_r, out_res_r;
  logic pend_valid_r, out_valid_r, out_last_r;

  // Decode of the latched transfer.
  logic [7:0]    win8, lim8, idx8, lkey8, src8, k8;
  logic [6:0]    idx7, lvel_c;
  logic [8:0]    lsum9, lkey9, sval_c;
  logic          win_ok, local_ok, cpl_ok;
  logic [KW-1:0] pv_addr, key_dec;
  logic [SW-1:0] srcw_dec;

  always_comb begin
    win8     = ({1'b0, acc_r} < MAXK8) ? {1'b0, acc_r} : MAXK8;
    lim8     = ({1'b0, lk_r} < MAXK8) ? {1'b0, lk_r} : MAXK8;
    win_ok   = (note_r >= fmn_r) && ({1'b0, note_r} < ({1'b0, fmn_r} + win8));
    idx7     = note_r - fmn_r;
    idx8     = {1'b0, idx7};
    pv_addr  = idx8[KW-1:0];
    lkey8    = {2'b00, lkey_r};
    src8     = {5'b00000, src_r};
    if (cmd_r != CMD_NOTE_ON) lvel_c = 7'd0;
    else if (vel_r == 9'd0) lvel_c = 7'd1;
    else if (vel_r > 9'd127) lvel_c = 7'd127;
    else lvel_c = vel_r[6:0];
    lsum9    = {2'b00, idx7} + {2'b00, flk_r};
    lkey9    = lsum9 - 9'd1;
    local_ok = (lsum9 != 9'd0) && (lkey9 < {1'b0, lim8});
    cpl_ok   = (lkey8 < lim8) && ({4'b0000, src_r} < NS7);
    unique case (cmd_r)
      CMD_NOTE_ON, CMD_NOTE_OFF: begin
        key_dec  = lkey9[KW-1:0];
        srcw_dec = '0;
        sval_c   = (lvel_c != 7'd0) ? {lvel_c, 2'b11} : 9'd0;
      end
      CMD_COUPLER: begin
        key_dec  = lkey8[KW-1:0];
        srcw_dec = src8[SW-1:0];
        sval_c   = vel_r;
      end
      default: begin
        key_dec  = '0;
        srcw_dec = '0;
        sval_c   = 9'd0;
      end
    endcase
  end

  // Source table addressing and the maxima scan.
  logic [AW-1:0] sv_base, sv_raddr, sv_waddr;
  logic [SW-1:0] next_i;
  logic [8:0]    sv_old, eff;
  logic          sv_we, scan_last;

  always_comb begin
    sv_base   = AW'(key_r) * AW'(NUM_SOURCES);
    scan_last = (scan_i_r == LAST_SRC);
    next_i    = scan_last ? scan_i_r : scan_i_r + 1'b1;
    unique case (ctl.op)
      OP_SV_RD: sv_raddr = sv_base + AW'(srcw_r);
      OP_SCAN:  sv_raddr = sv_base + AW'(next_i);
      default:  sv_raddr = sv_base;
    endcase
    sv_old   = row_vld_r[key_r] ? sv_q : 9'd0;
    eff      = (scan_i_r == srcw_r) ? sval_r : sv_old;
    sv_we    = (ctl.op == OP_SCAN) && (!row_vld_r[key_r] || (scan_i_r == srcw_r));
    sv_waddr = sv_base + AW'(scan_i_r);
  end

  // Division level check and result formation.
  logic [6:0]  pv_old, dl_old, level;
  logic [8:0]  drv_vel;
  logic [17:0] mc_old;
  logic [10:0] mn11;
  logic        mn_ok, pv_same, lvl_same, out_free, can_push, push, fin_pop;
  logic        view;
  res_t        new_res;

  always_comb begin
    k8       = 8'(key_r);
    pv_old   = pv_vld_r[pv_addr] ? pv_q : 7'd0;
    pv_same  = (pv_old == lvel_r);
    mc_old   = mc_vld_r[key_r] ? mc_q : 18'd0;
    dl_old   = dl_vld_r[key_r] ? dl_q : 7'd0;
    if (ctl.op == OP_RED_CHK) drv_vel = red_on_r ? mc_old[8:0] : mc_old[17:9];
    else drv_vel = (ucount_r != 8'd0) ? remote_r : all_r;
    level    = drv_vel[8:2];
    lvl_same = (level == dl_old);
    out_free = !out_valid_r || out_ready;
    can_push = !pend_valid_r || out_free;
    view     = ({2'b00, flk_r} <= ({1'b0, k8} + 9'd1)) &&
               ({1'b0, k8} <= ({2'b00, flk_r} + {2'b00, acc_r}));
    mn11     = {3'b000, k8} + {4'b0000, fmn_r} - {4'b0000, flk_r} + 11'd1;
    mn_ok    = !mn11[10] && (mn11 < 11'd127);
    new_res  = '0;
    push     = 1'b0;
    unique case (ctl.op)
      OP_PV_CHK: begin
        new_res.kind     = KIND_ECHO;
        new_res.note     = note_r;
        new_res.velocity = {2'b00, lvel_r};
        push             = !pv_same && can_push;
      end
      OP_UPD: begin
        new_res.kind            = KIND_UPDATE;
        new_res.note            = k8[6:0];
        new_res.velocity        = all_r;
        new_res.remote_velocity = remote_r;
        new_res.in_view         = view;
        push                    = can_push;
      end
      OP_DRV_CHK, OP_RED_CHK: begin
        new_res.kind          = KIND_OUTPUT;
        new_res.note          = 7'(k8 + 8'd1);
        new_res.velocity      = {2'b00, level};
        new_res.division_note = mn_ok ? mn11[6:0] : 7'd0;
        new_res.midi_valid    = mn_ok;
        push                  = !lvl_same && can_push;
      end
      default: push = 1'b0;
    endcase
    fin_pop = (ctl.op == OP_FIN) && pend_valid_r && out_free;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmn_r <= 7'd0;
      flk_r <= 7'd1;
      acc_r <= 7'd0;
      lk_r  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_NOTE:        fmn_r <= cfg_data;
        CFG_FIRST_LOGICAL_KEY: flk_r <= cfg_data;
        CFG_ACCESSIBLE_KEYS:   acc_r <= cfg_data;
        CFG_LOGICAL_KEYS:      lk_r  <= cfg_data;
        default:               fmn_r <= fmn_r;
      endcase
    end
  end

  // Input capture on an accepted transfer.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      note_r <= in_note_num;
      lkey_r <= in_logical_key;
      vel_r  <= in_velocity;
      src_r  <= in_source;
    end
  end

  // Unison nesting count and redrive mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucount_r <= 8'd0;
      red_on_r <= 1'b0;
    end else if (ctl.op == OP_DEC) begin
      red_on_r <= (cmd_r == CMD_UNISON_SET);
      if (cmd_r == CMD_UNISON_SET && ucount_r != UNISON_MAX) begin
        ucount_r <= ucount_r + 8'd1;
      end else if (cmd_r == CMD_UNISON_CLR && ucount_r != 8'd0) begin
        ucount_r <= ucount_r - 8'd1;
      end
    end
  end

  // Key, source value and scan registers.
  always_ff @(posedge clk) begin
    if (ctl.op == OP_DEC) begin
      key_r    <= key_dec;
      key_ok_r <= (cmd_r == CMD_COUPLER) ? cpl_ok : local_ok;
      srcw_r   <= srcw_dec;
      sval_r   <= sval_c;
      lvel_r   <= lvel_c;
    end else if (ctl.op == OP_RED_CHK && (lvl_same || can_push)) begin
      key_r <= key_r + 1'b1;
    end
    if (ctl.op == OP_SV_CHK) begin
      scan_i_r <= '0;
      all_r    <= 9'd0;
      remote_r <= 9'd0;
    end else if (ctl.op == OP_SCAN) begin
      scan_i_r <= next_i;
      if (eff > all_r) all_r <= eff;
      if (scan_i_r != '0 && eff > remote_r) remote_r <= eff;
    end
  end

  // Memory arrays with registered reads.
  always_ff @(posedge clk) begin
    pv_q <= pv_mem[pv_addr];
    sv_q <= sv_mem[sv_raddr];
    mc_q <= mc_mem[key_r];
    dl_q <= dl_mem[key_r];
    if (ctl.op == OP_PV_CHK && push) pv_mem[pv_addr] <= lvel_r;
    if (sv_we) sv_mem[sv_waddr] <= eff;
    if (ctl.op == OP_UPD && push) mc_mem[key_r] <= {all_r, remote_r};
    if ((ctl.op == OP_DRV_CHK || ctl.op == OP_RED_CHK) && push) dl_mem[key_r] <= level;
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_vld_r  <= '0;
      row_vld_r <= '0;
      mc_vld_r  <= '0;
      dl_vld_r  <= '0;
    end else begin
      if (ctl.op == OP_PV_CHK && push) pv_vld_r[pv_addr] <= 1'b1;
      if (ctl.op == OP_SCAN && scan_last) row_vld_r[key_r] <= 1'b1;
      if (ctl.op == OP_UPD && push) mc_vld_r[key_r] <= 1'b1;
      if ((ctl.op == OP_DRV_CHK || ctl.op == OP_RED_CHK) && push) dl_vld_r[key_r] <= 1'b1;
    end
  end

  // One result is held back so that the final one can carry the last flag.
  always_ff @(posedge clk) begin
    if (push) begin
      pend_r <= new_res;
      if (pend_valid_r) begin
        out_res_r  <= pend_r;
        out_last_r <= 1'b0;
      end
    end else if (fin_pop) begin
      out_res_r  <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (push) pend_valid_r <= 1'b1;
      else if (fin_pop) pend_valid_r <= 1'b0;
      if ((push && pend_valid_r) || fin_pop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Status to the controller.
  always_comb begin
    st.cmd        = cmd_r;
    st.win_ok     = win_ok;
    st.uc_zero    = (ucount_r == 8'd0);
    st.uc_one     = (ucount_r == 8'd1);
    st.lim_zero   = (lim8 == 8'd0);
    st.key_ok     = key_ok_r;
    st.pv_same    = pv_same;
    st.sv_same    = (sv_old == sval_r);
    st.scan_last  = scan_last;
    st.lvl_same   = lvl_same;
    st.red_last   = (({1'b0, k8} + 9'd1) == {1'b0, lim8});
    st.can_push   = can_push;
    st.pend_valid = pend_valid_r;
    st.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

// ----- sv/keyboard_coupler_velocity_merge.sv -----
// Top level of the keyboard coupler velocity merge.
// One event is handled at a time. For a note on or note off inside the window
// and for a coupler key, the per-source velocities of the key are walked one
// entry per cycle through the read port of the source velocity memory. A
// unison-off first set or last clear re-drives every logical key in turn,
// a read state and a check state per key. Rejected or unchanged events go
// to the finish state without the scan. A stalled result port holds the event
// up. Results appear in order; the one that carries last closes the event,
// and a new event is taken only once its final result has been handed to the
// output register.
`timescale 1ns / 1ps
module keyboard_coupler_velocity_merge #(
  parameter int MAX_KEYS    = kcvm_pkg::MAX_KEYS_DEF,
  parameter int NUM_SOURCES = kcvm_pkg::NUM_SOURCES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [6:0] in_note_num,
  input  logic [5:0] in_logical_key,
  input  logic [8:0] in_velocity,
  input  logic [2:0] in_source,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [6:0] out_note,
  output logic [8:0] out_out_velocity,
  output logic [8:0] out_remote_velocity,
  output logic [6:0] out_division_note,
  output logic       out_midi_valid,
  output logic       out_in_view,
  output logic       out_last
);
  import kcvm_pkg::*;

  ctl_t  ctl;
  stat_t st;
  res_t  res;

  // Sequencer.
  kcvm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  // Tables, arithmetic and result staging.
  kcvm_dp #(
    .MAX_KEYS    (MAX_KEYS),
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (in_cmd),
    .in_note_num    (in_note_num),
    .in_logical_key (in_logical_key),
    .in_velocity    (in_velocity),
    .in_source      (in_source),
    .ctl            (ctl),
    .st             (st),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_res        (res),
    .out_last       (out_last)
  );

  // Result fields.
  assign out_kind            = res.kind;
  assign out_note            = res.note;
  assign out_out_velocity    = res.velocity;
  assign out_remote_velocity = res.remote_velocity;
  assign out_division_note   = res.division_note;
  assign out_midi_valid      = res.midi_valid;
  assign out_in_view         = res.in_view;

endmodule
